// ===== rtl/core/cbd_pkg.sv =====
package cbd_pkg;

  localparam int RAM_BYTES = 2048;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] PRD_NONE = 2'd0;
  localparam logic [1:0] PRD_READ = 2'd1;
  localparam logic [1:0] PRD_PEEK = 2'd2;

  localparam logic [15:0] RAM_TOP      = 16'h1FFF;
  localparam logic [15:0] PPU_TOP      = 16'h3FFF;
  localparam logic [15:0] OAM_DMA_PORT = 16'h4014;
  localparam logic [15:0] PAD1_ADDR    = 16'h4016;
  localparam logic [15:0] PAD2_ADDR    = 16'h4017;

  localparam logic [2:0] PHASE_EVEN = 3'd0;
  localparam logic [2:0] PHASE_ODD  = 3'd3;
  localparam logic [2:0] PHASE_LAST = 3'd5;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] bus_address;
    logic [1:0]  ppu_read;
    logic        ppu_write;
    logic [2:0]  ppu_reg;
    logic [7:0]  ppu_wdata;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        cpu_step;
    logic        nmi_to_cpu;
    logic        dma_busy;
  } res_t;

  typedef struct packed {
    res_t res;
    logic use_ram;
    logic dma_rd;
  } stage_t;

  typedef struct packed {
    logic              re;
    logic [RAM_AW-1:0] raddr;
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

// ===== rtl/core/cbd_ram.sv =====
module cbd_ram
  import cbd_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [RAM_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cbd_ctrl.sv =====
module cbd_ctrl
  import cbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [1:0]  req_type,
  input  logic [15:0] address,
  input  logic [7:0]  wdata,
  input  logic        read_only,
  input  logic        cart_hit,
  input  logic [7:0]  cart_data,
  input  logic [7:0]  ppu_rdata,
  input  logic [7:0]  pad_one,
  input  logic [7:0]  pad_two,
  input  logic        ppu_nmi,
  input  logic        cap_en,
  input  logic [7:0]  cap_data,
  output stage_t      stage_nxt,
  output ram_req_t    ram_req
);

  logic [7:0] pad_shift_r [2];
  logic [7:0] pad_shift_nxt [2];
  logic [7:0] dma_page_r, dma_page_nxt;
  logic [7:0] dma_index_r, dma_index_nxt;
  logic [7:0] dma_byte_r;
  logic       dma_running_r, dma_running_nxt;
  logic       dma_align_r, dma_align_nxt;
  logic [2:0] tick_phase_r, tick_phase_nxt;

  always_comb begin
    logic        do_rd;
    logic        peek;
    logic [15:0] a;
    logic        odd;

    stage_nxt        = '0;
    pad_shift_nxt[0] = pad_shift_r[0];
    pad_shift_nxt[1] = pad_shift_r[1];
    dma_page_nxt     = dma_page_r;
    dma_index_nxt    = dma_index_r;
    dma_running_nxt  = dma_running_r;
    dma_align_nxt    = dma_align_r;
    tick_phase_nxt   = tick_phase_r;
    do_rd            = 1'b0;
    peek             = 1'b0;
    a                = address;
    odd              = (tick_phase_r == PHASE_ODD);
    ram_req          = '0;

    unique case (req_type)
      REQ_READ: begin
        do_rd = 1'b1;
        peek  = read_only;
        stage_nxt.res.bus_address = address;
      end
      REQ_WRITE: begin
        stage_nxt.res.bus_address = address;
        if (cart_hit) begin
        end else if (address <= RAM_TOP) begin
          ram_req.we = acc;
        end else if (address <= PPU_TOP) begin
          stage_nxt.res.ppu_write = 1'b1;
          stage_nxt.res.ppu_reg   = address[2:0];
          stage_nxt.res.ppu_wdata = wdata;
        end else if (address == OAM_DMA_PORT) begin
          dma_page_nxt    = wdata;
          dma_index_nxt   = '0;
          dma_running_nxt = 1'b1;
        end else if (address == PAD1_ADDR) begin
          pad_shift_nxt[0] = pad_one;
        end else if (address == PAD2_ADDR) begin
          pad_shift_nxt[1] = pad_two;
        end
      end
      REQ_TICK: begin
        if (tick_phase_r == PHASE_EVEN || odd) begin
          if (dma_running_r) begin
            if (dma_align_r) begin
              if (odd) begin
                dma_align_nxt = 1'b0;
              end
            end else if (!odd) begin
              a     = {dma_page_r, dma_index_r};
              do_rd = 1'b1;
              stage_nxt.dma_rd          = 1'b1;
              stage_nxt.res.bus_address = a;
            end else begin
              stage_nxt.res.oam_write = 1'b1;
              stage_nxt.res.oam_index = dma_index_r;
              stage_nxt.res.oam_data  = dma_byte_r;
              dma_index_nxt           = dma_index_r + 8'd1;
              if (dma_index_r == 8'hFF) begin
                dma_running_nxt = 1'b0;
                dma_align_nxt   = 1'b1;
              end
            end
          end else begin
            stage_nxt.res.cpu_step = 1'b1;
          end
        end
        stage_nxt.res.nmi_to_cpu = ppu_nmi;
        tick_phase_nxt = (tick_phase_r >= PHASE_LAST) ? 3'd0 : tick_phase_r + 3'd1;
      end
      default: begin
      end
    endcase

    if (do_rd) begin
      if (cart_hit) begin
        stage_nxt.res.read_data = cart_data;
      end else if (a <= RAM_TOP) begin
        stage_nxt.use_ram = 1'b1;
      end else if (a <= PPU_TOP) begin
        stage_nxt.res.ppu_read  = peek ? PRD_PEEK : PRD_READ;
        stage_nxt.res.ppu_reg   = a[2:0];
        stage_nxt.res.read_data = ppu_rdata;
      end else if (a == PAD1_ADDR || a == PAD2_ADDR) begin
        stage_nxt.res.read_data = {7'd0, pad_shift_r[a[0]][7]};
        pad_shift_nxt[a[0]]     = {pad_shift_r[a[0]][6:0], 1'b0};
      end
    end

    stage_nxt.res.dma_busy = dma_running_nxt;
    ram_req.re    = acc;
    ram_req.raddr = a[RAM_AW-1:0];
    ram_req.waddr = address[RAM_AW-1:0];
    ram_req.wdata = wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_shift_r[0] <= '0;
      pad_shift_r[1] <= '0;
      dma_page_r     <= '0;
      dma_index_r    <= '0;
      dma_byte_r     <= '0;
      dma_running_r  <= 1'b0;
      dma_align_r    <= 1'b1;
      tick_phase_r   <= '0;
    end else begin
      if (acc) begin
        pad_shift_r[0] <= pad_shift_nxt[0];
        pad_shift_r[1] <= pad_shift_nxt[1];
        dma_page_r     <= dma_page_nxt;
        dma_index_r    <= dma_index_nxt;
        dma_running_r  <= dma_running_nxt;
        dma_align_r    <= dma_align_nxt;
        tick_phase_r   <= tick_phase_nxt;
      end
      if (cap_en) begin
        dma_byte_r <= cap_data;
      end
    end
  end

endmodule

// ===== rtl/core/cpu_bus_decode_with_sprite_dma.sv =====
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | req_type address wdata read_only cart_hit
//         |           |                     | cart_data ppu_rdata pad_one pad_two ppu_nmi
// out_    | output    | out_valid/out_stall | read_data bus_address ppu_* oam_* cpu_step
//         |           |                     | nmi_to_cpu dma_busy
//
// One transaction per cycle sustained while out_stall stays low; each result passes
// through the registered work RAM read port and then the output register.
// Pad, phase and DMA control state update on accept; DMA byte and RAM data join in stage 1.
// Reset is synchronous; work RAM contents are not cleared.
// A stalled output holds; one more transaction is absorbed in stage 1 before in_stall rises.
module cpu_bus_decode_with_sprite_dma
  import cbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_wdata,
  input  logic        in_read_only,
  input  logic        in_cart_hit,
  input  logic [7:0]  in_cart_data,
  input  logic [7:0]  in_ppu_rdata,
  input  logic [7:0]  in_pad_one,
  input  logic [7:0]  in_pad_two,
  input  logic        in_ppu_nmi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_bus_address,
  output logic [1:0]  out_ppu_read,
  output logic        out_ppu_write,
  output logic [2:0]  out_ppu_reg,
  output logic [7:0]  out_ppu_wdata,
  output logic        out_oam_write,
  output logic [7:0]  out_oam_index,
  output logic [7:0]  out_oam_data,
  output logic        out_cpu_step,
  output logic        out_nmi_to_cpu,
  output logic        out_dma_busy
);

  logic     acc;
  logic     s1_adv;
  logic     s1_vld_r;
  stage_t   s1_r, s1_nxt;
  logic     out_vld_r;
  res_t     out_r, out_nxt;
  ram_req_t ram_req;
  logic [7:0] ram_q;
  logic [7:0] fin_byte;

  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign acc      = in_valid && !in_stall;
  assign fin_byte = s1_r.use_ram ? ram_q : s1_r.res.read_data;

  always_comb begin
    out_nxt           = s1_r.res;
    out_nxt.read_data = s1_r.dma_rd ? 8'd0 : fin_byte;
  end

  cbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req_type  (in_req_type),
    .address   (in_address),
    .wdata     (in_wdata),
    .read_only (in_read_only),
    .cart_hit  (in_cart_hit),
    .cart_data (in_cart_data),
    .ppu_rdata (in_ppu_rdata),
    .pad_one   (in_pad_one),
    .pad_two   (in_pad_two),
    .ppu_nmi   (in_ppu_nmi),
    .cap_en    (s1_adv && s1_r.dma_rd),
    .cap_data  (fin_byte),
    .stage_nxt (s1_nxt),
    .ram_req   (ram_req)
  );

  cbd_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_read_data   = out_r.read_data;
  assign out_bus_address = out_r.bus_address;
  assign out_ppu_read    = out_r.ppu_read;
  assign out_ppu_write   = out_r.ppu_write;
  assign out_ppu_reg     = out_r.ppu_reg;
  assign out_ppu_wdata   = out_r.ppu_wdata;
  assign out_oam_write   = out_r.oam_write;
  assign out_oam_index   = out_r.oam_index;
  assign out_oam_data    = out_r.oam_data;
  assign out_cpu_step    = out_r.cpu_step;
  assign out_nmi_to_cpu  = out_r.nmi_to_cpu;
  assign out_dma_busy    = out_r.dma_busy;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r))
    else $error("input stalled without a full pipeline");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ppu_read != PRD_NONE) |-> !out_ppu_write)
    else $error("ppu read and write in one transaction");

  a_oam_no_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_r.res.oam_write) |-> (!s1_r.use_ram && !s1_r.dma_rd))
    else $error("oam write tick also reads the bus");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> s1_vld_r)
    else $error("stage 1 transaction lost");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cbd_pkg::*;

  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam int PLAN_COPY  = 0;
  localparam int CHECK_COPY = 1;
  localparam int HOLD_CYCLES = 48;
  localparam int FLOOD_ITEMS = 60;
  localparam int RANDOM_ITEMS = 460;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        read_only;
    logic        cart_hit;
    logic [7:0]  cart_data;
    logic [7:0]  ppu_rdata;
    logic [7:0]  pad_one;
    logic [7:0]  pad_two;
    logic        ppu_nmi;
    logic        drain;
    logic        dense;
  } bus_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_TOGGLE, RX_BUSY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_wdata = '0;
  logic        in_read_only = 1'b0;
  logic        in_cart_hit = 1'b0;
  logic [7:0]  in_cart_data = '0;
  logic [7:0]  in_ppu_rdata = '0;
  logic [7:0]  in_pad_one = '0;
  logic [7:0]  in_pad_two = '0;
  logic        in_ppu_nmi = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic [15:0] out_bus_address;
  logic [1:0]  out_ppu_read;
  logic        out_ppu_write;
  logic [2:0]  out_ppu_reg;
  logic [7:0]  out_ppu_wdata;
  logic        out_oam_write;
  logic [7:0]  out_oam_index;
  logic [7:0]  out_oam_data;
  logic        out_cpu_step;
  logic        out_nmi_to_cpu;
  logic        out_dma_busy;

  cpu_bus_decode_with_sprite_dma dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_address     (in_address),
    .in_wdata       (in_wdata),
    .in_read_only   (in_read_only),
    .in_cart_hit    (in_cart_hit),
    .in_cart_data   (in_cart_data),
    .in_ppu_rdata   (in_ppu_rdata),
    .in_pad_one     (in_pad_one),
    .in_pad_two     (in_pad_two),
    .in_ppu_nmi     (in_ppu_nmi),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_bus_address(out_bus_address),
    .out_ppu_read   (out_ppu_read),
    .out_ppu_write  (out_ppu_write),
    .out_ppu_reg    (out_ppu_reg),
    .out_ppu_wdata  (out_ppu_wdata),
    .out_oam_write  (out_oam_write),
    .out_oam_index  (out_oam_index),
    .out_oam_data   (out_oam_data),
    .out_cpu_step   (out_cpu_step),
    .out_nmi_to_cpu (out_nmi_to_cpu),
    .out_dma_busy   (out_dma_busy)
  );

  always #4 clk = ~clk;

  // Two copies of the bus state: one steers stimulus, one predicts on acceptance.
  logic [7:0] ram_m   [2][RAM_BYTES];
  logic [7:0] pad_m   [2][2];
  logic [7:0] page_m  [2];
  logic [7:0] idx_m   [2];
  logic [7:0] byte_m  [2];
  logic       run_m   [2];
  logic       align_m [2];
  logic [2:0] phase_m [2];

  bus_item_t pending_items[$];
  res_t      expected_results[$];
  bit        slot_written[RAM_BYTES];
  int        written_slots[$];
  int        items_added;
  int        mismatches;

  function automatic void reset_bus_model(input int m);
    pad_m[m][0] = 8'h00;
    pad_m[m][1] = 8'h00;
    page_m[m] = 8'h00;
    idx_m[m] = 8'h00;
    byte_m[m] = 8'h00;
    run_m[m] = 1'b0;
    align_m[m] = 1'b1;
    phase_m[m] = 3'd0;
  endfunction

  function automatic logic [7:0] read_bus(input int m, input logic [15:0] addr,
      input logic peek, input logic hit, input logic [7:0] cdata,
      input logic [7:0] pdata, inout res_t r);
    logic [7:0] b;
    b = 8'h00;
    if (hit) begin
      b = cdata;
    end else if (addr <= RAM_TOP) begin
      b = ram_m[m][addr % RAM_BYTES];
    end else if (addr <= PPU_TOP) begin
      r.ppu_read = peek ? PRD_PEEK : PRD_READ;
      r.ppu_reg = addr[2:0];
      b = pdata;
    end else if (addr == PAD1_ADDR || addr == PAD2_ADDR) begin
      b = {7'd0, pad_m[m][addr[0]][7]};
      pad_m[m][addr[0]] = pad_m[m][addr[0]] << 1;
    end
    return b;
  endfunction

  function automatic res_t predict_bus(input int m, input bus_item_t it);
    res_t r;
    logic [7:0] b;
    logic odd;
    r = '0;
    case (it.req)
      REQ_READ: begin
        r.bus_address = it.addr;
        b = read_bus(m, it.addr, it.read_only, it.cart_hit, it.cart_data, it.ppu_rdata, r);
        r.read_data = b;
      end
      REQ_WRITE: begin
        r.bus_address = it.addr;
        if (!it.cart_hit) begin
          if (it.addr <= RAM_TOP) begin
            ram_m[m][it.addr % RAM_BYTES] = it.wdata;
          end else if (it.addr <= PPU_TOP) begin
            r.ppu_write = 1'b1;
            r.ppu_reg = it.addr[2:0];
            r.ppu_wdata = it.wdata;
          end else if (it.addr == OAM_DMA_PORT) begin
            page_m[m] = it.wdata;
            idx_m[m] = 8'h00;
            run_m[m] = 1'b1;
          end else if (it.addr == PAD1_ADDR) begin
            pad_m[m][0] = it.pad_one;
          end else if (it.addr == PAD2_ADDR) begin
            pad_m[m][1] = it.pad_two;
          end
        end
      end
      REQ_TICK: begin
        if (phase_m[m] == PHASE_EVEN || phase_m[m] == PHASE_ODD) begin
          odd = (phase_m[m] == PHASE_ODD);
          if (!run_m[m]) begin
            r.cpu_step = 1'b1;
          end else if (align_m[m]) begin
            if (odd) align_m[m] = 1'b0;
          end else if (!odd) begin
            r.bus_address = {page_m[m], idx_m[m]};
            b = read_bus(m, {page_m[m], idx_m[m]}, 1'b0, it.cart_hit, it.cart_data,
                         it.ppu_rdata, r);
            byte_m[m] = b;
          end else begin
            r.oam_write = 1'b1;
            r.oam_index = idx_m[m];
            r.oam_data = byte_m[m];
            idx_m[m] = idx_m[m] + 8'd1;
            if (idx_m[m] == 8'd0) begin
              run_m[m] = 1'b0;
              align_m[m] = 1'b1;
            end
          end
        end
        r.nmi_to_cpu = it.ppu_nmi;
        phase_m[m] = (phase_m[m] == PHASE_LAST) ? 3'd0 : phase_m[m] + 3'd1;
      end
      default: begin
      end
    endcase
    r.dma_busy = run_m[m];
    return r;
  endfunction

  // Keeps work RAM reads on written bytes only, then advances the planning copy.
  task automatic add_item(input bus_item_t item);
    bus_item_t it;
    logic [15:0] s;
    it = item;
    if (it.req == REQ_READ && !it.cart_hit && it.addr <= RAM_TOP &&
        !slot_written[it.addr % RAM_BYTES]) begin
      if (written_slots.size() > 0) begin
        s = 16'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
        it.addr[RAM_AW-1:0] = s[RAM_AW-1:0];
      end else begin
        it.cart_hit = 1'b1;
      end
    end
    if (it.req == REQ_TICK && !it.cart_hit && phase_m[PLAN_COPY] == PHASE_EVEN &&
        run_m[PLAN_COPY] && !align_m[PLAN_COPY]) begin
      s = {page_m[PLAN_COPY], idx_m[PLAN_COPY]};
      if (s <= RAM_TOP && !slot_written[s % RAM_BYTES]) it.cart_hit = 1'b1;
    end
    if (it.req == REQ_WRITE && !it.cart_hit && it.addr <= RAM_TOP &&
        !slot_written[it.addr % RAM_BYTES]) begin
      slot_written[it.addr % RAM_BYTES] = 1'b1;
      written_slots.push_back(it.addr % RAM_BYTES);
    end
    void'(predict_bus(PLAN_COPY, it));
    pending_items.push_back(it);
    items_added++;
  endtask

  function automatic bus_item_t mk_item(input logic [1:0] req, input logic [15:0] addr,
      input logic [7:0] wdata);
    bus_item_t it;
    it = '0;
    it.req = req;
    it.addr = addr;
    it.wdata = wdata;
    return it;
  endfunction

  function automatic bus_item_t rand_item(input bit allow_dma);
    bus_item_t it;
    int pick;
    it = '0;
    it.addr = 16'($urandom);
    it.wdata = 8'($urandom);
    it.read_only = 1'($urandom);
    it.cart_data = 8'($urandom);
    it.ppu_rdata = 8'($urandom);
    it.pad_one = 8'($urandom);
    it.pad_two = 8'($urandom);
    it.ppu_nmi = 1'($urandom);
    it.cart_hit = ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.req = REQ_TICK;
      it.cart_hit = 1'($urandom);
    end else if (pick < 42) begin
      it.req = REQ_NOP;
    end else begin
      it.req = (pick < 71) ? REQ_READ : REQ_WRITE;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: it.addr = 16'($urandom_range(0, RAM_TOP));
        6, 7, 8, 9:       it.addr = 16'($urandom_range(RAM_TOP + 1, PPU_TOP));
        10, 11:           it.addr = $urandom_range(0, 1) ? PAD1_ADDR : PAD2_ADDR;
        12:               it.addr = OAM_DMA_PORT;
        default: begin
        end
      endcase
      if (!allow_dma && it.req == REQ_WRITE && it.addr == OAM_DMA_PORT) it.addr = PAD2_ADDR;
    end
    return it;
  endfunction

  function automatic bus_item_t rand_tick();
    bus_item_t it;
    it = rand_item(1'b0);
    it.req = REQ_TICK;
    return it;
  endfunction

  task automatic run_sprite_dma(input logic [7:0] page, input logic [7:0] stop_index);
    bus_item_t it;
    it = rand_item(1'b0);
    it.req = REQ_WRITE;
    it.addr = OAM_DMA_PORT;
    it.wdata = page;
    it.cart_hit = 1'b0;
    it.drain = 1'b1;
    add_item(it);
    while (run_m[PLAN_COPY] && idx_m[PLAN_COPY] < stop_index) begin
      add_item(($urandom_range(0, 7) == 0) ? rand_item(1'b0) : rand_tick());
    end
  endtask

  task automatic build_stimulus();
    bus_item_t it;
    logic [15:0] addrs[12];
    logic [15:0] port;
    int n;
    int first_random;
    int flood_count;
    bit second_dma_done;

    it = mk_item(REQ_WRITE, 16'h0000, 8'h00); add_item(it);
    it = mk_item(REQ_WRITE, 16'h07FF, 8'hFF); add_item(it);
    it = mk_item(REQ_READ, 16'h0000, 8'h00); add_item(it);
    it = mk_item(REQ_READ, RAM_TOP, 8'h00); add_item(it);
    it = mk_item(REQ_READ, 16'h1800, 8'h00); add_item(it);
    it = mk_item(REQ_WRITE, RAM_TOP + 16'd1, 8'hA5); add_item(it);
    it = mk_item(REQ_WRITE, PPU_TOP, 8'h5A); add_item(it);
    it = mk_item(REQ_READ, 16'h2002, 8'h00); it.ppu_rdata = 8'hFF; add_item(it);
    it = mk_item(REQ_READ, PPU_TOP, 8'h00); it.read_only = 1'b1; it.ppu_rdata = 8'h81;
    add_item(it);
    it = mk_item(REQ_READ, 16'hFFFF, 8'h00); it.cart_hit = 1'b1; it.cart_data = 8'hFF;
    add_item(it);
    it = mk_item(REQ_WRITE, 16'h0000, 8'h77); it.cart_hit = 1'b1; add_item(it);
    it = mk_item(REQ_READ, 16'h0800, 8'h00); add_item(it);
    it = mk_item(REQ_READ, OAM_DMA_PORT, 8'h00); add_item(it);
    it = mk_item(REQ_WRITE, 16'h5000, 8'hFF); add_item(it);
    it = mk_item(REQ_WRITE, PAD1_ADDR, 8'h00); it.pad_one = 8'h81; add_item(it);
    it = mk_item(REQ_WRITE, PAD2_ADDR, 8'h00); it.pad_two = 8'h80; add_item(it);
    it = mk_item(REQ_READ, PAD1_ADDR, 8'h00); add_item(it);
    it = mk_item(REQ_READ, PAD1_ADDR, 8'h00); it.read_only = 1'b1; add_item(it);
    it = mk_item(REQ_READ, PAD2_ADDR, 8'h00); add_item(it);
    it = mk_item(REQ_NOP, 16'hFFFF, 8'hFF); add_item(it);
    it = mk_item(REQ_WRITE, OAM_DMA_PORT, 8'h00); add_item(it);
    repeat (3) begin
      it = mk_item(REQ_TICK, 16'h0000, 8'h00); it.ppu_nmi = 1'b1; add_item(it);
    end
    it = mk_item(REQ_WRITE, OAM_DMA_PORT, 8'hFF); add_item(it);

    // pad page: source addresses span both pad ports and the DMA register itself
    run_sprite_dma(8'h40, 8'h20);

    first_random = items_added;
    flood_count = 0;
    second_dma_done = 1'b0;
    while (items_added - first_random < RANDOM_ITEMS) begin
      if (flood_count < 2 && items_added - first_random >= 150 + 300 * flood_count) begin
        repeat (FLOOD_ITEMS) begin
          it = rand_item(1'b1);
          it.dense = 1'b1;
          add_item(it);
        end
        flood_count++;
      end
      if (!second_dma_done && items_added - first_random >= 350) begin
        run_sprite_dma(8'($urandom), 8'h10);
        first_random = first_random + 0;
        second_dma_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        3: begin
          port = $urandom_range(0, 1) ? PAD1_ADDR : PAD2_ADDR;
          it = rand_item(1'b0);
          it.req = REQ_WRITE;
          it.addr = port;
          it.cart_hit = 1'b0;
          add_item(it);
          repeat ($urandom_range(1, 10)) begin
            it = rand_item(1'b0);
            if ($urandom_range(0, 3) != 0) begin
              it.req = REQ_READ;
              it.addr = port;
              it.cart_hit = 1'b0;
            end
            add_item(it);
          end
        end
        4: begin
          n = $urandom_range(2, 12);
          for (int i = 0; i < n; i++) begin
            it = rand_item(1'b0);
            it.req = REQ_WRITE;
            it.addr = 16'($urandom_range(0, RAM_TOP));
            it.cart_hit = 1'b0;
            addrs[i] = it.addr;
            add_item(it);
          end
          for (int i = 0; i < n; i++) begin
            it = rand_item(1'b0);
            it.req = REQ_READ;
            it.addr = addrs[i] ^ (16'($urandom_range(0, 3)) << RAM_AW);
            it.cart_hit = 1'b0;
            add_item(it);
          end
        end
        5: begin
          it = rand_item(1'b0);
          it.req = REQ_WRITE;
          it.addr = OAM_DMA_PORT;
          it.cart_hit = 1'b0;
          add_item(it);
          repeat ($urandom_range(12, 150)) begin
            add_item(($urandom_range(0, 7) == 0) ? rand_item(1'b1) : rand_tick());
          end
        end
        6: begin
          repeat ($urandom_range(4, 16)) begin
            it = rand_item(1'b0);
            it.req = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
            it.addr = 16'($urandom_range(RAM_TOP + 1, PPU_TOP));
            add_item(it);
          end
        end
        7: begin
          repeat ($urandom_range(10, 40)) add_item(rand_tick());
        end
        8: begin
          it = rand_item(1'b1);
          it.drain = 1'b1;
          add_item(it);
          repeat ($urandom_range(5, 20)) add_item(rand_item(1'b1));
        end
        default: begin
          repeat ($urandom_range(8, 30)) add_item(rand_item(1'b1));
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
      input logic [15:0] want);
    if (mismatches < 50) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
      input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // driver
  bus_item_t cur_item;
  int        gap_left;
  int        burst_left;
  logic      flood_run = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = $urandom_range(1, 24);
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_bus(CHECK_COPY, cur_item));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() == 0 ||
            (pending_items[0].drain && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0 && !pending_items[0].dense) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_item.req;
          in_address <= cur_item.addr;
          in_wdata <= cur_item.wdata;
          in_read_only <= cur_item.read_only;
          in_cart_hit <= cur_item.cart_hit;
          in_cart_data <= cur_item.cart_data;
          in_ppu_rdata <= cur_item.ppu_rdata;
          in_pad_one <= cur_item.pad_one;
          in_pad_two <= cur_item.pad_two;
          in_ppu_nmi <= cur_item.ppu_nmi;
          flood_run <= cur_item.dense;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off when a dense burst starts
  rx_mode_t rx_mode;
  int       rx_left;
  int       hold_left;
  logic     flood_seen = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_mode = RX_OPEN;
      rx_left = 0;
      hold_left = 0;
    end else begin
      flood_seen <= flood_run;
      if (flood_run && !flood_seen) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
          RX_SPARSE: out_stall <= ($urandom_range(0, 99) < 30);
          RX_TOGGLE: out_stall <= ~out_stall;
          RX_BUSY:   out_stall <= ($urandom_range(0, 99) < 75);
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  // monitor
  res_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("transaction with nothing expected", 16'h1, 16'h0);
      end else begin
        want = expected_results.pop_front();
        check_field("read_data", 16'(out_read_data), 16'(want.read_data));
        check_field("bus_address", out_bus_address, want.bus_address);
        check_field("ppu_read", 16'(out_ppu_read), 16'(want.ppu_read));
        check_field("ppu_write", 16'(out_ppu_write), 16'(want.ppu_write));
        check_field("ppu_reg", 16'(out_ppu_reg), 16'(want.ppu_reg));
        check_field("ppu_wdata", 16'(out_ppu_wdata), 16'(want.ppu_wdata));
        check_field("oam_write", 16'(out_oam_write), 16'(want.oam_write));
        check_field("oam_index", 16'(out_oam_index), 16'(want.oam_index));
        check_field("oam_data", 16'(out_oam_data), 16'(want.oam_data));
        check_field("cpu_step", 16'(out_cpu_step), 16'(want.cpu_step));
        check_field("nmi_to_cpu", 16'(out_nmi_to_cpu), 16'(want.nmi_to_cpu));
        check_field("dma_busy", 16'(out_dma_busy), 16'(want.dma_busy));
      end
    end
  end

  initial begin
    mismatches = 0;
    items_added = 0;
    reset_bus_model(PLAN_COPY);
    reset_bus_model(CHECK_COPY);
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cbd_pkg.sv
rtl/core/cbd_ram.sv
rtl/core/cbd_ctrl.sv
rtl/core/cpu_bus_decode_with_sprite_dma.sv
tb/sv/tb_top.sv
